>>> rtl/core/vsrc_pkg.sv
// Shared types, widths and constants of the video sync rate controller.
package vsrc_pkg;

    // Window store geometry.
    localparam int DEF_WINDOW_DEPTH = 64;

    // Field widths.
    localparam int WIN_SIZE_W  = 7;
    localparam int THR_W       = 16;
    localparam int STEP_W      = 8;
    localparam int SPEED_W     = 10;
    localparam int TIME_W      = 32;
    localparam int DUR_W       = 16;
    localparam int RATE_W      = 10;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;

    // Largest window length that the size register can express.
    localparam int WIN_SIZE_MAX = (1 << WIN_SIZE_W) - 1;

    // Delay arithmetic: base times rate times speed, scaled down by 2^16.
    localparam int BASE_W = TIME_W + 1;
    localparam int RF_W   = RATE_W + SPEED_W;
    localparam int PROD_W = BASE_W + RF_W + 1;
    localparam int Q_FRAC = 16;

    // Stream word widths.
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 80;

    // Register reset values.
    localparam logic [WIN_SIZE_W-1:0] RST_WINDOW_SIZE = 7'd5;
    localparam logic [THR_W-1:0]      RST_THR_WEAK    = 16'd50;
    localparam logic [THR_W-1:0]      RST_THR_STRONG  = 16'd100;
    localparam logic [THR_W-1:0]      RST_THR_SKIP    = 16'd200;
    localparam logic [THR_W-1:0]      RST_THR_RESET   = 16'd25;
    localparam logic [STEP_W-1:0]     RST_SPEED_STEP  = 8'd13;
    localparam logic [SPEED_W-1:0]    RST_SPEED_MAX   = 10'd320;
    localparam logic [SPEED_W-1:0]    RST_SPEED_MIN   = 10'd205;

    // Speed of 1.0 and the catch-up factor of 0.5, both Q2.8.
    localparam logic [SPEED_W-1:0] SPEED_ONE   = 10'd256;
    localparam logic [SPEED_W-1:0] SKIP_FACTOR = 10'd128;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE,
        REG_THR_WEAK,
        REG_THR_STRONG,
        REG_THR_SKIP,
        REG_THR_RESET,
        REG_SPEED_STEP,
        REG_SPEED_MAX,
        REG_SPEED_MIN
    } cfg_idx_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DECIDE,
        ST_SCALE,
        ST_MULTIPLY,
        ST_FINISH
    } state_t;

endpackage

>>> rtl/core/video_sync_rate_controller_core.sv
// Top level of the video sync rate controller: window update, mean, decision and delay.
//
// Once per display refresh a word arrives with the picture timestamp, the next
// timestamp, the duration, the master clock and the rate scale. The block stores
// the clock gap in a moving-average window held in a RAM, forms the mean with a
// bit-serial divider and from it decides whether the picture is shown, which sync
// speed applies and the delay until the next refresh. One word is in work at a time:
// it passes the update, divide, decide, scale, multiply and finish states in turn, and
// the divider forms the SUM_W-bit mean one quotient bit per cycle (SUM_W is 38 at the
// default window depth of 64). The next word is taken as soon as the previous one has
// entered the output register, even while that result still waits to be taken.
// A write of the window size clears the window at once; no clearing pass is needed.
module video_sync_rate_controller_core
    import vsrc_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream. s_tdata, from bit 0 up: picture_pts[31:0], next_pts[63:32],
    // picture_duration[79:64], clock_now[111:80], rate_scale[121:112], zero pad.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,   // next_valid
    // Result stream. m_tdata, from bit 0 up: show[0], delay_ms[32:1],
    // applied_speed[42:33], average_gap[74:43], zero pad.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NMAX   = (WINDOW_DEPTH < WIN_SIZE_MAX) ? WINDOW_DEPTH : WIN_SIZE_MAX;
    localparam int FILL_W = $clog2(NMAX + 1);
    localparam int SUM_W  = TIME_W + $clog2(NMAX);
    localparam int ADDR_W = $clog2(WINDOW_DEPTH);

    // Control state.
    state_t                  state_reg, state_next;
    logic [WIN_SIZE_W-1:0]   window_size_reg, window_size_next;
    logic [THR_W-1:0]        thr_weak_reg, thr_weak_next;
    logic [THR_W-1:0]        thr_strong_reg, thr_strong_next;
    logic [THR_W-1:0]        thr_skip_reg, thr_skip_next;
    logic [THR_W-1:0]        thr_reset_reg, thr_reset_next;
    logic [STEP_W-1:0]       speed_step_reg, speed_step_next;
    logic [SPEED_W-1:0]      speed_max_reg, speed_max_next;
    logic [SPEED_W-1:0]      speed_min_reg, speed_min_next;
    logic [FILL_W-1:0]       write_pos_reg, write_pos_next;
    logic [FILL_W-1:0]       fill_count_reg, fill_count_next;
    logic signed [SUM_W-1:0] window_sum_reg, window_sum_next;
    logic [SPEED_W-1:0]      sync_speed_reg, sync_speed_next;
    logic                    out_valid_reg, out_valid_next;

    // Payload of the word in work.
    logic signed [TIME_W-1:0] pts_reg, pts_next;
    logic signed [TIME_W-1:0] npts_reg, npts_next;
    logic                     nval_reg, nval_next;
    logic [DUR_W-1:0]         dur_reg, dur_next;
    logic [RATE_W-1:0]        rate_reg, rate_next;
    logic signed [TIME_W-1:0] sample_reg, sample_next;
    logic signed [TIME_W-1:0] avg_reg, avg_next;
    logic                     show_reg, show_next;
    logic [SPEED_W-1:0]       applied_reg, applied_next;
    logic [SPEED_W-1:0]       factor_reg, factor_next;
    logic signed [BASE_W-1:0] base_reg, base_next;
    logic [RF_W-1:0]          rf_reg, rf_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [OUT_DATA_W-1:0]    out_data_reg, out_data_next;

    // Stream fields and helpers.
    logic signed [TIME_W-1:0] in_pts, in_npts, in_clk;
    logic signed [TIME_W:0]   in_diff;
    logic signed [TIME_W-1:0] in_sample;
    logic                     in_accept;
    logic [FILL_W-1:0]        n_eff;
    logic                     ram_we;
    logic [TIME_W-1:0]        ram_rdata;
    logic                     div_start;
    logic                     div_done;
    logic signed [SUM_W-1:0]  div_quot;

    // Decision helpers.
    logic signed [TIME_W+1:0]  avg_x;
    logic signed [TIME_W+1:0]  weak_x, strong_x, skip_x, reset_x;
    logic [SPEED_W:0]          s_up;
    logic signed [SPEED_W+1:0] s_dn;
    logic signed [PROD_W-1:0]  prod_adj;
    logic signed [PROD_W-1:0]  prod_q;
    logic signed [TIME_W-1:0]  delay_sat;

    assign in_pts  = s_tdata[31:0];
    assign in_npts = s_tdata[63:32];
    assign in_clk  = s_tdata[111:80];

    // Sample is the timestamp minus the clock, saturated to 32 bits.
    always_comb
    begin
        in_diff = {in_pts[TIME_W-1], in_pts} - {in_clk[TIME_W-1], in_clk};
        if (in_diff[TIME_W] != in_diff[TIME_W-1])
        begin
            in_sample = in_diff[TIME_W] ? {1'b1, {(TIME_W-1){1'b0}}}
                                        : {1'b0, {(TIME_W-1){1'b1}}};
        end
        else
        begin
            in_sample = in_diff[TIME_W-1:0];
        end
    end

    // Effective window length: zero counts as one, large values clamp to the depth.
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            n_eff = FILL_W'(1);
        end
        else if (window_size_reg > WIN_SIZE_W'(NMAX))
        begin
            n_eff = FILL_W'(NMAX);
        end
        else
        begin
            n_eff = FILL_W'(window_size_reg);
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Window store: the oldest entry is read at acceptance, the new sample written back.
    vsrc_ram #(
        .DATA_W (TIME_W),
        .DEPTH  (WINDOW_DEPTH)
    ) u_window_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(write_pos_reg)),
        .wdata (sample_reg),
        .re    (in_accept),
        .raddr (ADDR_W'(write_pos_reg)),
        .rdata (ram_rdata)
    );

    // Mean of the window.
    vsrc_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (FILL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (window_sum_next),
        .divisor  (fill_count_next),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Widened comparands for the threshold tests.
    always_comb
    begin
        avg_x    = {{2{avg_reg[TIME_W-1]}}, avg_reg};
        weak_x   = $signed({{(TIME_W+2-THR_W){1'b0}}, thr_weak_reg});
        strong_x = $signed({{(TIME_W+2-THR_W){1'b0}}, thr_strong_reg});
        skip_x   = $signed({{(TIME_W+2-THR_W){1'b0}}, thr_skip_reg});
        reset_x  = $signed({{(TIME_W+2-THR_W){1'b0}}, thr_reset_reg});
        s_up     = {1'b0, sync_speed_reg} + {{(SPEED_W+1-STEP_W){1'b0}}, speed_step_reg};
        s_dn     = $signed({2'b00, sync_speed_reg})
                 - $signed({{(SPEED_W+2-STEP_W){1'b0}}, speed_step_reg});
    end

    // Delay: truncate the Q16 product toward zero, then saturate to 32 bits.
    always_comb
    begin
        prod_adj = prod_reg;
        if (prod_reg[PROD_W-1])
        begin
            prod_adj = prod_reg + $signed({{(PROD_W-Q_FRAC){1'b0}}, {Q_FRAC{1'b1}}});
        end
        prod_q = prod_adj >>> Q_FRAC;
        if (prod_q[PROD_W-1:TIME_W-1] == '0 || prod_q[PROD_W-1:TIME_W-1] == '1)
        begin
            delay_sat = prod_q[TIME_W-1:0];
        end
        else
        begin
            delay_sat = prod_q[PROD_W-1] ? {1'b1, {(TIME_W-1){1'b0}}}
                                         : {1'b0, {(TIME_W-1){1'b1}}};
        end
    end

    // Sequencer: next state, datapath next values and configuration writes.
    always_comb
    begin
        state_next       = state_reg;
        window_size_next = window_size_reg;
        thr_weak_next    = thr_weak_reg;
        thr_strong_next  = thr_strong_reg;
        thr_skip_next    = thr_skip_reg;
        thr_reset_next   = thr_reset_reg;
        speed_step_next  = speed_step_reg;
        speed_max_next   = speed_max_reg;
        speed_min_next   = speed_min_reg;
        write_pos_next   = write_pos_reg;
        fill_count_next  = fill_count_reg;
        window_sum_next  = window_sum_reg;
        sync_speed_next  = sync_speed_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        pts_next         = pts_reg;
        npts_next        = npts_reg;
        nval_next        = nval_reg;
        dur_next         = dur_reg;
        rate_next        = rate_reg;
        sample_next      = sample_reg;
        avg_next         = avg_reg;
        show_next        = show_reg;
        applied_next     = applied_reg;
        factor_next      = factor_reg;
        base_next        = base_reg;
        rf_next          = rf_reg;
        prod_next        = prod_reg;
        out_data_next    = out_data_reg;
        ram_we           = 1'b0;
        div_start        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    pts_next    = in_pts;
                    npts_next   = in_npts;
                    nval_next   = s_tuser;
                    dur_next    = s_tdata[79:64];
                    rate_next   = s_tdata[121:112];
                    sample_next = in_sample;
                    state_next  = ST_UPDATE;
                end
            end

            // Add the new sample and, once full, drop the oldest one.
            ST_UPDATE:
            begin
                ram_we = 1'b1;
                if (fill_count_reg < n_eff)
                begin
                    window_sum_next = window_sum_reg + SUM_W'(sample_reg);
                    fill_count_next = fill_count_reg + 1'b1;
                end
                else
                begin
                    window_sum_next = window_sum_reg + SUM_W'(sample_reg)
                                    - SUM_W'($signed(ram_rdata));
                end
                write_pos_next = (write_pos_reg + 1'b1 == n_eff) ? '0 : write_pos_reg + 1'b1;
                div_start      = 1'b1;
                state_next     = ST_DIVIDE;
            end

            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    avg_next   = div_quot[TIME_W-1:0];
                    state_next = ST_DECIDE;
                end
            end

            // Threshold ladder: skip, strong, weak, reset, hold.
            ST_DECIDE:
            begin
                show_next    = 1'b1;
                applied_next = SPEED_ONE;
                base_next    = nval_reg ? ({npts_reg[TIME_W-1], npts_reg}
                                          - {pts_reg[TIME_W-1], pts_reg})
                                        : $signed({{(BASE_W-DUR_W){1'b0}}, dur_reg});
                if (avg_x > skip_x)
                begin
                    show_next = 1'b0;
                    base_next = {avg_reg[TIME_W-1], avg_reg};
                end
                else if (avg_x < -skip_x)
                begin
                    show_next = 1'b0;
                    base_next = '0;
                end
                else if (avg_x > strong_x)
                begin
                    applied_next = speed_max_reg;
                end
                else if (avg_x < -strong_x)
                begin
                    applied_next = speed_min_reg;
                end
                else if (avg_x > weak_x)
                begin
                    applied_next    = (s_up < {1'b0, speed_max_reg}) ? s_up[SPEED_W-1:0]
                                                                   : speed_max_reg;
                    sync_speed_next = applied_next;
                end
                else if (avg_x < -weak_x)
                begin
                    applied_next    = (s_dn > $signed({2'b00, speed_min_reg}))
                                    ? s_dn[SPEED_W-1:0] : speed_min_reg;
                    sync_speed_next = applied_next;
                end
                else if (avg_x < reset_x && -avg_x < reset_x)
                begin
                    applied_next = SPEED_ONE;
                end
                else
                begin
                    applied_next = sync_speed_reg;
                end
                factor_next = (avg_x > skip_x) ? SKIP_FACTOR : applied_next;
                state_next  = ST_SCALE;
            end

            ST_SCALE:
            begin
                rf_next    = rate_reg * factor_reg;
                state_next = ST_MULTIPLY;
            end

            ST_MULTIPLY:
            begin
                prod_next  = base_reg * $signed({1'b0, rf_reg});
                state_next = ST_FINISH;
            end

            // Load the output register once it is free.
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{(OUT_DATA_W-1-TIME_W-SPEED_W-TIME_W){1'b0}},
                                      avg_reg, applied_reg, delay_sat, show_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes; a window size write also empties the window.
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_WINDOW_SIZE:
                begin
                    window_size_next = cfg_data[WIN_SIZE_W-1:0];
                    write_pos_next   = '0;
                    fill_count_next  = '0;
                    window_sum_next  = '0;
                end
                REG_THR_WEAK:   thr_weak_next   = cfg_data[THR_W-1:0];
                REG_THR_STRONG: thr_strong_next = cfg_data[THR_W-1:0];
                REG_THR_SKIP:   thr_skip_next   = cfg_data[THR_W-1:0];
                REG_THR_RESET:  thr_reset_next  = cfg_data[THR_W-1:0];
                REG_SPEED_STEP: speed_step_next = cfg_data[STEP_W-1:0];
                REG_SPEED_MAX:  speed_max_next  = cfg_data[SPEED_W-1:0];
                REG_SPEED_MIN:  speed_min_next  = cfg_data[SPEED_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_size_reg <= RST_WINDOW_SIZE;
            thr_weak_reg    <= RST_THR_WEAK;
            thr_strong_reg  <= RST_THR_STRONG;
            thr_skip_reg    <= RST_THR_SKIP;
            thr_reset_reg   <= RST_THR_RESET;
            speed_step_reg  <= RST_SPEED_STEP;
            speed_max_reg   <= RST_SPEED_MAX;
            speed_min_reg   <= RST_SPEED_MIN;
            write_pos_reg   <= '0;
            fill_count_reg  <= '0;
            window_sum_reg  <= '0;
            sync_speed_reg  <= SPEED_ONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            thr_weak_reg    <= thr_weak_next;
            thr_strong_reg  <= thr_strong_next;
            thr_skip_reg    <= thr_skip_next;
            thr_reset_reg   <= thr_reset_next;
            speed_step_reg  <= speed_step_next;
            speed_max_reg   <= speed_max_next;
            speed_min_reg   <= speed_min_next;
            write_pos_reg   <= write_pos_next;
            fill_count_reg  <= fill_count_next;
            window_sum_reg  <= window_sum_next;
            sync_speed_reg  <= sync_speed_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pts_reg      <= pts_next;
        npts_reg     <= npts_next;
        nval_reg     <= nval_next;
        dur_reg      <= dur_next;
        rate_reg     <= rate_next;
        sample_reg   <= sample_next;
        avg_reg      <= avg_next;
        show_reg     <= show_next;
        applied_reg  <= applied_next;
        factor_reg   <= factor_next;
        base_reg     <= base_next;
        rf_reg       <= rf_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The fill count never runs past the effective window length.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= n_eff)
        else $error("fill count exceeds window length");

    // The write pointer always stays inside the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        write_pos_reg < n_eff)
        else $error("write pointer outside window");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide state");

    // The sync speed only moves as a result of a decision.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(sync_speed_reg) |-> $past(state_reg == ST_DECIDE))
        else $error("sync speed changed outside a decision");

endmodule

>>> rtl/core/vsrc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module vsrc_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/vsrc_div.sv
// Bit-serial signed divider, truncating toward zero, one quotient bit per cycle.
module vsrc_div
    import vsrc_pkg::*;
#(
    parameter int DIVIDEND_W = 38,
    parameter int DIVISOR_W  = 7,
    parameter int CNT_W      = $clog2(DIVIDEND_W + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic        [DIVISOR_W-1:0]  divisor,
    output logic                         done,
    output logic signed [DIVIDEND_W-1:0] quotient
);

    logic                  busy_reg,  busy_next;
    logic [CNT_W-1:0]      cnt_reg,   cnt_next;
    logic                  neg_reg,   neg_next;
    logic [DIVIDEND_W-1:0] dq_reg,    dq_next;
    logic [DIVISOR_W-1:0]  rem_reg,   rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg,   dvs_next;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[DIVIDEND_W-1]};
        fits     = (rem_sh >= {1'b0, dvs_reg});
        rem_diff = rem_sh - {1'b0, dvs_reg};
    end

    // Control and datapath next values.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            neg_next  = dividend[DIVIDEND_W-1];
            dq_next   = dividend[DIVIDEND_W-1] ? -dividend : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            cnt_next = cnt_reg - 1'b1;
            dq_next  = {dq_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = neg_reg ? -$signed(dq_reg) : $signed(dq_reg);

endmodule

>>> tb/sv/tb_video_sync_rate_controller_core.sv
// Self-checking testbench for the video sync rate controller core.
module tb_video_sync_rate_controller_core;
    import vsrc_pkg::*;

    // One refresh request as it travels on the input stream.
    typedef struct {
        logic [31:0] pts;
        logic [31:0] next_pts;
        logic        next_valid;
        logic [15:0] duration;
        logic [31:0] clock;
        logic [9:0]  rate;
    } frame_t;

    // One refresh decision as it travels on the result stream.
    typedef struct {
        logic        show;
        logic [31:0] delay;
        logic [9:0]  speed;
        logic [31:0] gap;
    } refresh_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    video_sync_rate_controller_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Register copies kept by the predictor.
    int cfg_win_size   = RST_WINDOW_SIZE;
    int cfg_thr_weak   = RST_THR_WEAK;
    int cfg_thr_strong = RST_THR_STRONG;
    int cfg_thr_skip   = RST_THR_SKIP;
    int cfg_thr_reset  = RST_THR_RESET;
    int cfg_step       = RST_SPEED_STEP;
    int cfg_max        = RST_SPEED_MAX;
    int cfg_min        = RST_SPEED_MIN;

    // Moving-average window and sync speed as the predictor tracks them.
    int          gap_window [DEF_WINDOW_DEPTH];
    int unsigned gap_wr_pos = 0;
    int unsigned gap_fill = 0;
    longint      gap_sum = 0;
    int          sync_speed = SPEED_ONE;

    frame_t   queued_frames[$];
    refresh_t expected_refreshes[$];
    frame_t   drv_frame;
    refresh_t seen_word;
    refresh_t due_word;
    int       cfg_plan [8];

    logic word_taken = 1'b0;
    bit   steady = 1'b0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   rx_hold_len = 0;
    int   rx_hold_seq = 0;
    int   hold_seen = 0;
    int   errors = 0;
    int   frames_taken = 0;
    int   refreshes_checked = 0;
    int   settings_used = 0;

    // Clock with a period of 4.
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #4000000;
        $display("tb_video_sync_rate_controller_core: errors");
        $finish;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Mirror a register write into the predictor.
    function automatic void apply_reg(input cfg_idx_t idx, input logic [15:0] value);
        case (idx)
            REG_WINDOW_SIZE:
            begin
                cfg_win_size = value & 16'h7F;
                gap_wr_pos = 0;
                gap_fill = 0;
                gap_sum = 0;
            end
            REG_THR_WEAK:   cfg_thr_weak = value;
            REG_THR_STRONG: cfg_thr_strong = value;
            REG_THR_SKIP:   cfg_thr_skip = value;
            REG_THR_RESET:  cfg_thr_reset = value;
            REG_SPEED_STEP: cfg_step = value & 16'hFF;
            REG_SPEED_MAX:  cfg_max = value & 16'h3FF;
            REG_SPEED_MIN:  cfg_min = value & 16'h3FF;
            default: ;
        endcase
    endfunction

    // Push one gap sample into the window, take the mean and decide the refresh.
    function automatic refresh_t predict_refresh(input frame_t f);
        refresh_t    r;
        longint      pts_v;
        longint      npts_v;
        longint      clk_v;
        longint      rate_v;
        longint      mean;
        longint      base;
        longint      factor;
        longint      prod;
        int          sample;
        int unsigned n;
        int unsigned slot;
        int          applied;
        int          s;
        pts_v = $signed(f.pts);
        npts_v = $signed(f.next_pts);
        clk_v = $signed(f.clock);
        rate_v = f.rate;
        n = (cfg_win_size == 0) ? 1 :
            (cfg_win_size > DEF_WINDOW_DEPTH) ? DEF_WINDOW_DEPTH : cfg_win_size;
        sample = int'(clamp32(pts_v - clk_v));
        slot = gap_wr_pos % n;

        // Add the new sample; once full, drop the one it overwrites.
        if (gap_fill < n)
        begin
            gap_sum += sample;
            gap_fill++;
        end
        else
        begin
            gap_sum += longint'(sample) - longint'(gap_window[slot]);
        end
        gap_window[slot] = sample;
        gap_wr_pos = (slot + 1) % n;
        mean = gap_sum / longint'(gap_fill);

        // Threshold bands, from the widest inward.
        base = f.next_valid ? (npts_v - pts_v) : longint'(f.duration);
        factor = 0;
        applied = SPEED_ONE;
        r.show = 1'b1;
        if (mean > cfg_thr_skip)
        begin
            r.show = 1'b0;
            base = mean;
            factor = SKIP_FACTOR;
        end
        else if (mean < -cfg_thr_skip)
        begin
            r.show = 1'b0;
            base = 0;
        end
        else if (mean > cfg_thr_strong)
        begin
            applied = cfg_max;
        end
        else if (mean < -cfg_thr_strong)
        begin
            applied = cfg_min;
        end
        else if (mean > cfg_thr_weak)
        begin
            s = sync_speed + cfg_step;
            applied = (s < cfg_max) ? s : cfg_max;
            sync_speed = applied & 'h3FF;
        end
        else if (mean < -cfg_thr_weak)
        begin
            s = sync_speed - cfg_step;
            applied = (s > cfg_min) ? s : cfg_min;
            sync_speed = applied & 'h3FF;
        end
        else if (mean < cfg_thr_reset && -mean < cfg_thr_reset)
        begin
            applied = SPEED_ONE;
        end
        else
        begin
            applied = sync_speed;
        end
        if (factor == 0)
            factor = applied;

        // Q16 product, truncated toward zero and saturated.
        prod = clamp32((base * rate_v * factor) / 64'sd65536);
        r.delay = prod[31:0];
        r.speed = applied[9:0];
        r.gap = mean[31:0];
        return r;
    endfunction

    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Gap target near one of the threshold bands or near zero, either sign.
    function automatic int drift_target();
        int band;
        case ($urandom_range(0, 4))
            0: band = cfg_thr_reset;
            1: band = cfg_thr_weak;
            2: band = cfg_thr_strong;
            3: band = cfg_thr_skip;
            default: band = 0;
        endcase
        band = band + $urandom_range(0, 40) - 20;
        return $urandom_range(0, 1) ? band : -band;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
                     $signed(want), $signed(got));
            errors++;
        end
    endtask

    task automatic queue_frame(input logic [31:0] pts, input logic [31:0] next_pts,
                               input logic next_valid, input logic [15:0] duration,
                               input logic [31:0] clock, input logic [9:0] rate);
        frame_t f;
        f.pts = pts;
        f.next_pts = next_pts;
        f.next_valid = next_valid;
        f.duration = duration;
        f.clock = clock;
        f.rate = rate;
        queued_frames.push_back(f);
    endtask

    // Frame whose pts leads a random clock by the given gap.
    task automatic queue_gap(input int gap, input logic next_valid, input int rate);
        logic [31:0] clock;
        clock = $urandom();
        queue_frame(clock + gap, clock + gap + 33, next_valid, 16'd40, clock, 10'(rate));
    endtask

    task automatic queue_random_frame(input int drift);
        logic [31:0] clock;
        logic [31:0] pts;
        logic [31:0] next_pts;
        logic [15:0] duration;
        logic [9:0]  rate;
        clock = $urandom();
        pts = clock + drift + $urandom_range(0, 30) - 15;
        if ($urandom_range(0, 79) == 0)
            pts = $urandom();
        next_pts = ($urandom_range(0, 7) == 0) ? $urandom() : pts + $urandom_range(0, 80);
        duration = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(10, 50));
        case ($urandom_range(0, 49))
            0: rate = '0;
            1, 2, 3, 4: rate = 10'($urandom_range(0, 1023));
            default: rate = 10'($urandom_range(200, 320));
        endcase
        queue_frame(pts, next_pts, 1'($urandom_range(0, 1)), duration, clock, rate);
    endtask

    // Wait until nothing is queued, offered or outstanding.
    task automatic wait_drained();
        while (queued_frames.size() != 0 || s_tvalid || expected_refreshes.size() != 0)
            @(negedge clk);
    endtask

    // Write the registers selected by mask from cfg_plan, one per cycle.
    task automatic program_regs(input logic [7:0] mask);
        @(negedge clk);
        for (int i = 0; i < 8; i++)
        begin
            if (mask[i])
            begin
                cfg_we <= 1'b1;
                cfg_index <= cfg_idx_t'(i);
                cfg_data <= cfg_plan[i][15:0];
                apply_reg(cfg_idx_t'(i), cfg_plan[i][15:0]);
                @(negedge clk);
            end
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic plan_defaults();
        cfg_plan[REG_WINDOW_SIZE] = RST_WINDOW_SIZE;
        cfg_plan[REG_THR_WEAK] = RST_THR_WEAK;
        cfg_plan[REG_THR_STRONG] = RST_THR_STRONG;
        cfg_plan[REG_THR_SKIP] = RST_THR_SKIP;
        cfg_plan[REG_THR_RESET] = RST_THR_RESET;
        cfg_plan[REG_SPEED_STEP] = RST_SPEED_STEP;
        cfg_plan[REG_SPEED_MAX] = RST_SPEED_MAX;
        cfg_plan[REG_SPEED_MIN] = RST_SPEED_MIN;
    endtask

    task automatic plan_random();
        int r;
        r = $urandom_range(0, 60);
        cfg_plan[REG_THR_RESET] = r;
        cfg_plan[REG_THR_WEAK] = r + $urandom_range(0, 80);
        cfg_plan[REG_THR_STRONG] = cfg_plan[REG_THR_WEAK] + $urandom_range(0, 150);
        cfg_plan[REG_THR_SKIP] = cfg_plan[REG_THR_STRONG] + $urandom_range(0, 300);
        cfg_plan[REG_SPEED_STEP] = $urandom_range(5, 40);
        cfg_plan[REG_SPEED_MAX] = $urandom_range(256, 700);
        cfg_plan[REG_SPEED_MIN] = $urandom_range(100, 256);
        case ($urandom_range(0, 7))
            0: cfg_plan[REG_WINDOW_SIZE] = 1;
            1: cfg_plan[REG_WINDOW_SIZE] = 2;
            2: cfg_plan[REG_WINDOW_SIZE] = 3;
            3: cfg_plan[REG_WINDOW_SIZE] = 8;
            4: cfg_plan[REG_WINDOW_SIZE] = 16;
            5: cfg_plan[REG_WINDOW_SIZE] = DEF_WINDOW_DEPTH;
            default: cfg_plan[REG_WINDOW_SIZE] = $urandom_range(0, 65535);
        endcase
        // Now and then a raw 16-bit value, so every data bit toggles.
        for (int i = 1; i < 8; i++)
            if ($urandom_range(0, 9) == 0)
                cfg_plan[i] = $urandom_range(0, 65535);
    endtask

    // Input driver: offers queued frames with random idle gaps, none in steady phases.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || word_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (queued_frames.size() != 0)
            begin
                drv_frame = queued_frames.pop_front();
                s_tdata <= {6'b0, drv_frame.rate, drv_frame.clock, drv_frame.duration,
                            drv_frame.next_pts, drv_frame.pts};
                s_tuser <= drv_frame.next_valid;
                s_tvalid <= 1'b1;
                send_gap = steady ? 0 : pick_idle();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls outside steady phases, plus long hold-offs on request.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_seen != rx_hold_seq)
        begin
            hold_seen = rx_hold_seq;
            stall_left = rx_hold_len;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (steady || $urandom_range(0, 3) != 0)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            stall_left = pick_idle();
            m_tready <= 1'b0;
        end
    end

    // Monitor: predicts on every accepted frame and checks every result word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            word_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                expected_refreshes.push_back(predict_refresh(drv_frame));
                frames_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                seen_word.show = m_tdata[0];
                seen_word.delay = m_tdata[32:1];
                seen_word.speed = m_tdata[42:33];
                seen_word.gap = m_tdata[74:43];
                if (expected_refreshes.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got %0h",
                             $time, m_tdata);
                    errors++;
                end
                else
                begin
                    due_word = expected_refreshes.pop_front();
                    compare_field("show", due_word.show, seen_word.show);
                    compare_field("delay_ms", due_word.delay, seen_word.delay);
                    compare_field("applied_speed", due_word.speed, seen_word.speed);
                    compare_field("average_gap", due_word.gap, seen_word.gap);
                    refreshes_checked++;
                end
            end
        end
    end

    // Stimulus: directed cases, then register phases with random frames.
    initial
    begin
        int count;
        int drift;
        logic [7:0] mask;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset register values, window still filling.
        queue_gap(0, 1'b1, 256);
        queue_gap(30, 1'b0, 256);
        queue_gap(90, 1'b1, 300);
        wait_drained();

        // Single-entry window, so each frame sets the mean directly.
        plan_defaults();
        cfg_plan[REG_WINDOW_SIZE] = 1;
        cfg_plan[REG_SPEED_STEP] = 40;
        program_regs(8'hFF);
        queue_gap(300, 1'b1, 256);     // skip ahead: catch-up delay at half speed
        queue_gap(-300, 1'b1, 256);    // skip behind: no delay
        queue_gap(150, 1'b1, 256);     // strong ahead
        queue_gap(-150, 1'b0, 256);    // strong behind
        for (int i = 0; i < 3; i++)
            queue_gap(75, 1'b1, 256);  // weak ahead, stepping up into the limit
        for (int i = 0; i < 4; i++)
            queue_gap(-75, 1'b1, 256); // weak behind, stepping down into the limit
        queue_gap(30, 1'b1, 256);      // between bands: hold sync speed
        queue_gap(10, 1'b1, 256);      // inside reset band
        // Sample saturation both ways, and delay saturation.
        queue_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'd0, 32'h8000_0000, 10'h3FF);
        queue_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 16'hFFFF, 32'h7FFF_FFFF, 10'h3FF);
        queue_frame(32'h0, 32'h7FFF_FFFF, 1'b1, 16'd0, 32'h0, 10'h3FF);
        queue_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'd0, 32'h7FFF_FFFF, 10'h3FF);
        queue_frame(32'h100, 32'h0, 1'b0, 16'hFFFF, 32'h100, 10'h3FF);
        queue_frame(32'h100, 32'h200, 1'b1, 16'd20, 32'h100, 10'h0);
        queue_frame(32'h100, 32'h200, 1'b0, 16'd0, 32'h100, 10'h200);
        wait_drained();

        // Register phases: extremes first, then random settings.
        for (int phase = 0; phase < 12; phase++)
        begin
            mask = 8'hFF;
            case (phase)
                0:
                begin
                    // Zero window size and all thresholds zero.
                    cfg_plan = '{0, 0, 0, 0, 0, 0, 1023, 1};
                end
                1:
                begin
                    // Oversized window and widest thresholds.
                    cfg_plan = '{127, 65535, 65535, 65535, 65535, 255, 1023, 0};
                end
                2:
                begin
                    // Full window with speed limits out of order.
                    cfg_plan = '{DEF_WINDOW_DEPTH, 20, 400, 800, 5, 255, 100, 600};
                end
                3:
                begin
                    plan_defaults();
                    cfg_plan[REG_WINDOW_SIZE] = 2;
                end
                default:
                begin
                    plan_random();
                    if ($urandom_range(0, 1) == 0)
                        mask[REG_WINDOW_SIZE] = 1'b0;
                end
            endcase
            program_regs(mask);
            steady = (phase % 4 == 1);

            // Hold the result side off while frames keep coming.
            if (phase == 3)
            begin
                rx_hold_len = 400;
                rx_hold_seq++;
            end

            count = $urandom_range(60, 110);
            drift = drift_target();
            for (int i = 0; i < count; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    drift = drift_target();
                queue_random_frame(drift);
            end
            wait_drained();
        end

        steady = 1'b0;
        wait_drained();
        repeat (60) @(negedge clk);
        $display("Ran %0d frames over %0d register settings; %0d result words compared.",
                 frames_taken, settings_used, refreshes_checked);
        $display("Windows from 1 to full depth, every threshold band, saturation cases.");
        if (errors == 0)
        begin
            $display("tb_video_sync_rate_controller_core: clean");
        end
        else
        begin
            $display("tb_video_sync_rate_controller_core: errors");
        end
        $finish;
    end

endmodule
